FILE: hdl/otdt_pkg.sv
// Shared types and constants for the one-shot delay timer table.
package otdt_pkg;

  localparam int Slots     = 16;
  localparam int JobIdBits = 8;
  localparam int DelayBits = 31;
  localparam int CntBits   = $clog2(Slots + 1);

  localparam logic [DelayBits-1:0] DelayMax = {DelayBits{1'b1}};

  // Opcodes of an input beat
  localparam logic OpAdd  = 1'b0;
  localparam logic OpTick = 1'b1;

  // Result kinds
  localparam logic KindFired  = 1'b0;
  localparam logic KindReject = 1'b1;

  // Contents of one timer slot
  typedef struct packed {
    logic                 pending;
    logic [JobIdBits-1:0] job;
    logic [DelayBits-1:0] delay;
  } slot_t;

endpackage

FILE: hdl/otdt_cell.sv
// One timer slot of the ring: loaded by an add, rotated one place per scan cycle.
module otdt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           wr_i,
  input  otdt_pkg::slot_t next_i,
  input  otdt_pkg::slot_t wr_data_i,
  output otdt_pkg::slot_t slot_o
);
  import otdt_pkg::*;

  logic                 pending_q, pending_d;
  logic [JobIdBits-1:0] job_q, job_d;
  logic [DelayBits-1:0] delay_q, delay_d;

  // Select load, rotate or hold
  always_comb begin
    pending_d = pending_q;
    job_d     = job_q;
    delay_d   = delay_q;
    if (wr_i) begin
      pending_d = wr_data_i.pending;
      job_d     = wr_data_i.job;
      delay_d   = wr_data_i.delay;
    end else if (shift_i) begin
      pending_d = next_i.pending;
      job_d     = next_i.job;
      delay_d   = next_i.delay;
    end
  end

  // Clear the pending flag on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    delay_q <= delay_d;
  end

  assign slot_o = '{pending: pending_q, job: job_q, delay: delay_q};

endmodule

FILE: hdl/one_shot_delay_timer_table.sv
// Top level: ring of timer slots, tick scan control and result register.
// An add writes the next free slot from idle; a rejection of an add to a full table
// appears on the result ports in the cycle after it. A tick keeps busy high through
// the scan and flush states: the ring rotates one slot per cycle past the head compare,
// then a final state flushes the last fired beat; the receiver cannot stall.
// Reset clears the counter, the fill count and every pending flag.
module one_shot_delay_timer_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [otdt_pkg::JobIdBits-1:0] job_id_i,
  input  logic [otdt_pkg::DelayBits-1:0] delay_ms_i,
  output logic                           strobe_o,
  output logic                           kind_o,
  output logic [otdt_pkg::JobIdBits-1:0] fired_job_o,
  output logic                           last_o
);
  import otdt_pkg::*;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [DelayBits-1:0] elapsed_q, elapsed_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic [CntBits-1:0]   scan_q, scan_d;
  logic                 held_valid_q, held_valid_d;
  logic [JobIdBits-1:0] held_job_q, held_job_d;

  logic                 strobe_q, strobe_d;
  logic                 kind_q, kind_d;
  logic [JobIdBits-1:0] job_q, job_d;
  logic                 last_q, last_d;

  slot_t cells [Slots];
  slot_t head_back;
  slot_t new_slot;
  logic  accept, add_go, shift, fire, full;

  assign accept   = start && (state_q == StIdle);
  assign full     = (count_q == CntBits'(Slots));
  assign add_go   = accept && (opcode_i == OpAdd) && !full;
  assign shift    = (state_q == StScan);
  assign fire     = cells[0].pending && (cells[0].delay < elapsed_q);
  assign new_slot = '{pending: 1'b1, job: job_id_i, delay: delay_ms_i};

  // Wrap the head back to the tail, done if it fires
  always_comb begin
    head_back         = cells[0];
    head_back.pending = cells[0].pending && !fire;
  end

  // Build the ring of slots
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    slot_t next;
    if (i == Slots - 1) begin : g_tail
      assign next = head_back;
    end else begin : g_body
      assign next = cells[i+1];
    end
    otdt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .wr_i      (add_go && (count_q == CntBits'(i))),
      .next_i    (next),
      .wr_data_i (new_slot),
      .slot_o    (cells[i])
    );
  end

  // Sequence adds and tick scans
  always_comb begin
    state_d      = state_q;
    elapsed_d    = elapsed_q;
    count_d      = count_q;
    scan_d       = scan_q;
    held_valid_d = held_valid_q;
    held_job_d   = held_job_q;
    strobe_d     = 1'b0;
    kind_d       = kind_q;
    job_d        = job_q;
    last_d       = last_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (opcode_i == OpAdd) begin
            if (full) begin
              strobe_d = 1'b1;
              kind_d   = KindReject;
              job_d    = job_id_i;
              last_d   = 1'b1;
            end else begin
              count_d = count_q + CntBits'(1);
            end
          end else begin
            if (elapsed_q != DelayMax) begin
              elapsed_d = elapsed_q + DelayBits'(1);
            end
            scan_d  = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (fire) begin
          if (held_valid_q) begin
            strobe_d = 1'b1;
            kind_d   = KindFired;
            job_d    = held_job_q;
            last_d   = 1'b0;
          end
          held_valid_d = 1'b1;
          held_job_d   = cells[0].job;
        end
        scan_d = scan_q + CntBits'(1);
        if (scan_q == CntBits'(Slots - 1)) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (held_valid_q) begin
          strobe_d = 1'b1;
          kind_d   = KindFired;
          job_d    = held_job_q;
          last_d   = 1'b1;
        end
        held_valid_d = 1'b0;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      elapsed_q    <= '0;
      count_q      <= '0;
      scan_q       <= '0;
      held_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      elapsed_q    <= elapsed_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      held_valid_q <= held_valid_d;
      strobe_q     <= strobe_d;
    end
  end

  // Hold the result beat and the deferred fired job
  always_ff @(posedge clk_i) begin
    held_job_q <= held_job_d;
    kind_q     <= kind_d;
    job_q      <= job_d;
    last_q     <= last_d;
  end

  assign busy        = (state_q != StIdle);
  assign strobe_o    = strobe_q;
  assign kind_o      = kind_q;
  assign fired_job_o = job_q;
  assign last_o      = last_q;

endmodule
